// ===== sv/skbh_pkg.sv =====
`timescale 1ns / 1ps

package skbh_pkg;

    localparam int SUM_W       = 32;
    localparam int SHIFT_W     = 5;
    localparam int TSIZE_W     = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_INSENSITIVE = 2'd1;

    localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST = 20'd101;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_J = 8'h4A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    localparam logic [SHIFT_W-1:0] SHIFT_STEP = 5'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_WRAP = 5'd25;
    localparam logic [SHIFT_W-1:0] SHIFT_DROP = 5'd24;

    // one finished key sum travelling from front to back
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] raw_sum;
    } sum_req_t;

    function automatic logic [SHIFT_W-1:0] next_shift(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] t;
        t = s + SHIFT_STEP;
        if (t >= SHIFT_WRAP)
        begin
            t = t - SHIFT_DROP;
        end
        return t;
    endfunction

endpackage

// ===== sv/skbh_if.sv =====
`timescale 1ns / 1ps

interface hash_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] key_byte;
    logic       last_of_key;

    modport source (output valid, output kind, output key_byte, output last_of_key,
                    input ready);
    modport sink   (input valid, input kind, input key_byte, input last_of_key,
                    output ready);
endinterface

interface hash_out_if;
    logic                              valid;
    logic                              ready;
    logic [skbh_pkg::TSIZE_W-1:0]      bucket;
    logic [skbh_pkg::SUM_W-1:0]        raw_sum;

    modport source (output valid, output bucket, output raw_sum, input ready);
    modport sink   (input valid, input bucket, input raw_sum, output ready);
endinterface

interface cfg_if;
    logic                              valid;
    logic                              ready;
    logic [skbh_pkg::CFG_IDX_W-1:0]    index;
    logic [skbh_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/skbh_front.sv =====
`timescale 1ns / 1ps

module skbh_front (
    input  logic                clk,
    input  logic                rst_n,
    hash_in_if.sink             key_in,
    input  logic                case_insensitive,
    input  logic                queue_full,
    output skbh_pkg::sum_req_t  push
);

    logic [skbh_pkg::SUM_W-1:0]   running_sum_reg;
    logic [skbh_pkg::SHIFT_W-1:0] shift_reg;

    logic                         accept;
    logic [7:0]                   c_text;
    logic [7:0]                   c_lo;
    logic [7:0]                   c_hi;
    logic [skbh_pkg::SHIFT_W-1:0] shift1;
    logic [skbh_pkg::SHIFT_W-1:0] shift2;
    logic [skbh_pkg::SHIFT_W-1:0] shift_after;
    logic [skbh_pkg::SUM_W-1:0]   add_term;
    logic [skbh_pkg::SUM_W-1:0]   sum_after;

    assign key_in.ready = !queue_full;
    assign accept       = key_in.valid && key_in.ready;

    always_comb
    begin
        c_text = key_in.key_byte;
        if (case_insensitive && (c_text >= skbh_pkg::CHAR_LOWER_A)
                && (c_text <= skbh_pkg::CHAR_LOWER_Z))
        begin
            c_text = c_text - skbh_pkg::CASE_OFFSET;
        end
        c_lo   = skbh_pkg::CHAR_UPPER_A + {4'b0, key_in.key_byte[3:0]};
        c_hi   = skbh_pkg::CHAR_UPPER_J + {4'b0, key_in.key_byte[7:4]};
        shift1 = skbh_pkg::next_shift(shift_reg);
        shift2 = skbh_pkg::next_shift(shift1);
        if (key_in.kind)
        begin
            // binary byte: low nibble char then high nibble char, both positive
            add_term    = ({24'b0, c_lo} << shift_reg) + ({24'b0, c_hi} << shift1);
            shift_after = shift2;
        end
        else
        begin
            add_term    = {{24{c_text[7]}}, c_text} << shift_reg;
            shift_after = shift1;
        end
        sum_after = running_sum_reg + add_term;
    end

    assign push.valid   = accept && key_in.last_of_key;
    assign push.raw_sum = sum_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            shift_reg       <= '0;
        end
        else if (accept)
        begin
            if (key_in.last_of_key)
            begin
                running_sum_reg <= '0;
                shift_reg       <= '0;
            end
            else
            begin
                running_sum_reg <= sum_after;
                shift_reg       <= shift_after;
            end
        end
    end

endmodule

// ===== sv/skbh_queue.sv =====
`timescale 1ns / 1ps

module skbh_queue #(
    parameter int DEPTH = skbh_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  skbh_pkg::sum_req_t  push,
    input  logic                pop,
    output skbh_pkg::sum_req_t  head,
    output logic                full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [skbh_pkg::SUM_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;

    logic do_push;
    logic do_pop;

    assign full         = (count_reg == CNT_W'(DEPTH));
    assign head.valid   = (count_reg != '0);
    assign head.raw_sum = entry_reg[rd_ptr_reg];
    assign do_push      = push.valid && !full;
    assign do_pop       = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.raw_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/skbh_back.sv =====
`timescale 1ns / 1ps

module skbh_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  skbh_pkg::sum_req_t              head,
    output logic                            pop,
    input  logic [skbh_pkg::TSIZE_W-1:0]    table_size,
    hash_out_if.source                      hash_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                         state_reg;
    logic [skbh_pkg::SUM_W-1:0]     dividend_reg;
    logic [skbh_pkg::SUM_W-1:0]     sum_reg;
    logic [skbh_pkg::TSIZE_W-1:0]   rem_reg;
    logic [4:0]                     cnt_reg;
    logic                           out_valid_reg;
    logic [skbh_pkg::TSIZE_W-1:0]   bucket_reg;
    logic [skbh_pkg::SUM_W-1:0]     raw_sum_reg;

    logic [skbh_pkg::TSIZE_W:0]     trial;
    logic [skbh_pkg::TSIZE_W:0]     trial_diff;
    logic                           trial_ge;
    logic                           out_free;

    // restoring remainder, one dividend bit per cycle
    assign trial      = {rem_reg, dividend_reg[skbh_pkg::SUM_W-1]};
    assign trial_diff = trial - {1'b0, table_size};
    assign trial_ge   = (trial >= {1'b0, table_size});
    assign out_free   = !out_valid_reg || hash_out.ready;
    assign pop        = (state_reg == ST_IDLE) && head.valid;

    assign hash_out.valid   = out_valid_reg;
    assign hash_out.bucket  = bucket_reg;
    assign hash_out.raw_sum = raw_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dividend_reg  <= '0;
            sum_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            bucket_reg    <= '0;
            raw_sum_reg   <= '0;
        end
        else
        begin
            if ((state_reg == ST_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hash_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        dividend_reg <= head.raw_sum;
                        sum_reg      <= head.raw_sum;
                        rem_reg      <= '0;
                        cnt_reg      <= '1;
                        state_reg    <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    rem_reg      <= trial_ge ? trial_diff[skbh_pkg::TSIZE_W-1:0]
                                             : trial[skbh_pkg::TSIZE_W-1:0];
                    dividend_reg <= {dividend_reg[skbh_pkg::SUM_W-2:0], 1'b0};
                    cnt_reg      <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        bucket_reg    <= (table_size == '0) ? '0 : rem_reg;
                        raw_sum_reg   <= sum_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/string_key_bucket_hash.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake       payload
// key_in    in   valid / ready   kind, key_byte, last_of_key
// hash_out  out  valid / ready   bucket, raw_sum
// cfg       in   valid / ready   index, data (ready tied high)
//
// One key byte is taken every cycle while the queue is not full; the sum is
// updated in the same cycle. The last byte of a key queues its sum; the
// remainder unit takes one key at a time (load, 32 bit steps, hand-off), so
// short keys back up into the queue and then stall key_in.
// Reset clears the running sum, the queue and the output register.

module string_key_bucket_hash #(
    parameter int QUEUE_DEPTH = skbh_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    hash_in_if.sink     key_in,
    hash_out_if.source  hash_out,
    cfg_if.sink         cfg
);

    logic [skbh_pkg::TSIZE_W-1:0] table_size_reg;
    logic                         case_insensitive_reg;

    skbh_pkg::sum_req_t push;
    skbh_pkg::sum_req_t head;
    logic               pop;
    logic               queue_full;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg       <= skbh_pkg::TABLE_SIZE_RST;
            case_insensitive_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                skbh_pkg::REG_TABLE_SIZE:
                begin
                    table_size_reg <= cfg.data[skbh_pkg::TSIZE_W-1:0];
                end
                skbh_pkg::REG_CASE_INSENSITIVE:
                begin
                    case_insensitive_reg <= cfg.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    skbh_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .key_in           (key_in),
        .case_insensitive (case_insensitive_reg),
        .queue_full       (queue_full),
        .push             (push)
    );

    skbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    skbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .table_size (table_size_reg),
        .hash_out   (hash_out)
    );

endmodule

// ===== sv/skbh_checker.sv =====
`timescale 1ns / 1ps

module skbh_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [skbh_pkg::TSIZE_W-1:0]    bucket,
    input logic [skbh_pkg::SUM_W-1:0]      raw_sum,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [skbh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [skbh_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [skbh_pkg::TSIZE_W-1:0] ts_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_shadow_reg <= skbh_pkg::TABLE_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == skbh_pkg::REG_TABLE_SIZE))
        begin
            ts_shadow_reg <= cfg_data[skbh_pkg::TSIZE_W-1:0];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bucket) && $stable(raw_sum))
        else $error("result changed while stalled");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ts_shadow_reg != '0) |-> bucket < ts_shadow_reg)
        else $error("bucket not below table size");

    a_bucket_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ts_shadow_reg == '0) |-> bucket == '0)
        else $error("bucket non-zero for zero table size");

    a_bucket_le_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {12'b0, bucket} <= raw_sum)
        else $error("bucket exceeds raw sum");

endmodule

bind string_key_bucket_hash skbh_checker u_skbh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (hash_out.valid),
    .out_ready (hash_out.ready),
    .bucket    (hash_out.bucket),
    .raw_sum   (hash_out.raw_sum),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
);
